// File: sv/ppmd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppmd_pkg: shared types and constants of the PPM stream decoder
// Item structures for the byte and result channels, result kinds, the
// character codes of the header syntax and the limits on parsed values.
// ----------------------------------------------------------------------------
package ppmd_pkg;

	// Limits on header values.
	localparam int MAX_DIM      = 16383;
	localparam int DIM_W        = 14;
	localparam int MAXVAL_LIMIT = 255;
	// The number accumulator saturates just above the largest legal value,
	// so any over-long number still fails the range check.
	localparam int ACC_W        = 15;
	localparam int ACC_CAP      = MAX_DIM + 1;
	localparam int PIX_CNT_W    = 2 * DIM_W;

	// Character codes used by the header parser.
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_SIX   = 8'h36;
	localparam logic [7:0] CH_LOW_A = 8'h61;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] OPAQUE   = 8'hFF;

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_PIXEL  = 2'd1,
		KIND_ERROR  = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_file;
	} byte_item_t;

	typedef struct packed {
		logic [1:0]       result_kind;
		logic [31:0]      argb;
		logic [DIM_W-1:0] image_width;
		logic [DIM_W-1:0] image_height;
		logic             has_alpha;
		logic             last_pixel;
	} result_item_t;

	// Space, TAB, LF, VT, FF and CR.
	function automatic logic is_ws(input logic [7:0] b);
		return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= CH_ZERO) && (b <= CH_NINE);
	endfunction

endpackage

// File: sv/ppmd_pixel_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppmd_pixel_scale: channel scaling for one pixel
// Scales the four channel bytes of a pixel to floor(c * maxval / 255) and
// packs them as an ARGB word.
// ----------------------------------------------------------------------------
module ppmd_pixel_scale (
	input  logic [3:0][7:0] channels,
	input  logic [7:0]      maxval,
	output logic [31:0]     argb
);

	logic [3:0][15:0] prod;
	logic [3:0][15:0] quot_sum;

	// For products up to 255 * 255, (x + (x >> 8) + 1) >> 8 equals x / 255 exactly.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			prod[i]     = {8'd0, channels[i]} * {8'd0, maxval};
			quot_sum[i] = prod[i] + {8'd0, prod[i][15:8]} + 16'd1;
			argb[i*8 +: 8] = quot_sum[i][15:8];
		end
	end

endmodule

// File: sv/ppm_stream_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppm_stream_decoder: binary PPM (P6 / P6a) byte stream decoder
// Parses the header of a binary PPM file arriving one byte per item, emits a
// header result, then one scaled ARGB32 word per pixel, or an error result.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                   Payload        Direction
//  byte      byte_valid / byte_ready     byte_item      into the block
//  result    result_valid / result_ready result_item    out of the block
//
// A byte item that is taken goes into the input register, and the decode
// logic works on it there; the result register is loaded when that byte item
// moves on, and a new byte item is taken in every cycle while results flow.
// The decode stage stalls only while the result register holds an item that
// has not been taken; the input register then keeps its byte item and
// byte_ready stays low until the result goes.
// Reset returns the parser to the first magic byte; no clearing pass is needed.
// After a byte item marked end of file the parser starts over with the next.
//
module ppm_stream_decoder (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   byte_valid,
	output logic                   byte_ready,
	input  ppmd_pkg::byte_item_t   byte_item,
	output logic                   result_valid,
	input  logic                   result_ready,
	output ppmd_pkg::result_item_t result_item
);

	// Parser phases, one-hot.
	typedef enum logic [11:0] {
		PH_MAGIC_P   = 12'b0000_0000_0001,
		PH_MAGIC_6   = 12'b0000_0000_0010,
		PH_MAGIC_SEP = 12'b0000_0000_0100,
		PH_ALPHA_SEP = 12'b0000_0000_1000,
		PH_PRE_WS    = 12'b0000_0001_0000,
		PH_COMMENT   = 12'b0000_0010_0000,
		PH_POST_WS   = 12'b0000_0100_0000,
		PH_DIGITS    = 12'b0000_1000_0000,
		PH_TAIL      = 12'b0001_0000_0000,
		PH_GAP       = 12'b0010_0000_0000,
		PH_PIXELS    = 12'b0100_0000_0000,
		PH_WAIT      = 12'b1000_0000_0000
	} phase_t;

	// Input register.
	logic                 valid_s1;
	ppmd_pkg::byte_item_t item_s1;
	logic                 advance;

	// Parser state.
	phase_t                              phase_q;
	logic                                alpha_q;
	logic [ppmd_pkg::ACC_W-1:0]          acc_q;
	logic [ppmd_pkg::DIM_W-1:0]          width_q;
	logic [ppmd_pkg::DIM_W-1:0]          height_q;
	logic [7:0]                          maxval_q;
	logic [1:0]                          chan_idx_q;
	logic [23:0]                         chan_bytes_q;
	logic [ppmd_pkg::PIX_CNT_W-1:0]      pix_left_q;

	phase_t                              phase_nx;
	logic                                alpha_nx;
	logic [ppmd_pkg::ACC_W-1:0]          acc_nx;
	logic [ppmd_pkg::DIM_W-1:0]          width_nx;
	logic [ppmd_pkg::DIM_W-1:0]          height_nx;
	logic [7:0]                          maxval_nx;
	logic [1:0]                          chan_idx_nx;
	logic [23:0]                         chan_bytes_nx;
	logic [ppmd_pkg::PIX_CNT_W-1:0]      pix_left_nx;

	ppmd_pkg::kind_t                     kind;
	logic                                last;
	logic [7:0]                          b;
	logic [3:0]                          digit;
	logic [ppmd_pkg::ACC_W+2:0]          acc_ext;
	logic [ppmd_pkg::PIX_CNT_W-1:0]      pix_total;
	logic [ppmd_pkg::PIX_CNT_W-1:0]      pix_dec;
	logic [3:0][7:0]                     pix_channels;
	logic [31:0]                         pix_argb;
	ppmd_pkg::result_item_t              result_nx;

	// The input register takes a new byte whenever it is empty or its
	// current byte moves on in the same cycle.
	assign advance    = valid_s1 && (!result_valid || result_ready);
	assign byte_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_valid && byte_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready) begin
			item_s1 <= byte_item;
		end
	end

	assign b         = item_s1.data_byte;
	assign digit     = 4'(b - ppmd_pkg::CH_ZERO);
	assign acc_ext   = {acc_q, 3'b000} + {2'b00, acc_q, 1'b0}
		+ {{(ppmd_pkg::ACC_W - 1){1'b0}}, digit};
	assign pix_total = {{ppmd_pkg::DIM_W{1'b0}}, width_q}
		* {{ppmd_pkg::DIM_W{1'b0}}, height_q};
	assign pix_dec   = (pix_left_q != '0) ? pix_left_q - ppmd_pkg::PIX_CNT_W'(1) : pix_left_q;

	// Alpha is fully opaque when the file carries no alpha byte.
	assign pix_channels = {alpha_q ? chan_bytes_q[23:16] : ppmd_pkg::OPAQUE,
		chan_bytes_q[15:8], chan_bytes_q[7:0], b};

	ppmd_pixel_scale u_scale (
		.channels (pix_channels),
		.maxval   (maxval_q),
		.argb     (pix_argb)
	);

	// Decode of one byte against the parser state.
	always_comb begin
		phase_nx      = phase_q;
		alpha_nx      = alpha_q;
		acc_nx        = acc_q;
		width_nx      = width_q;
		height_nx     = height_q;
		maxval_nx     = maxval_q;
		chan_idx_nx   = chan_idx_q;
		chan_bytes_nx = chan_bytes_q;
		pix_left_nx   = pix_left_q;
		kind          = ppmd_pkg::KIND_NONE;
		last          = 1'b0;

		case (phase_q)
			PH_MAGIC_P: begin
				if (b == ppmd_pkg::CH_P) phase_nx = PH_MAGIC_6;
				else kind = ppmd_pkg::KIND_ERROR;
			end
			PH_MAGIC_6: begin
				if (b == ppmd_pkg::CH_SIX) phase_nx = PH_MAGIC_SEP;
				else kind = ppmd_pkg::KIND_ERROR;
			end
			PH_MAGIC_SEP: begin
				if (b == ppmd_pkg::CH_LOW_A) begin
					alpha_nx = 1'b1;
					phase_nx = PH_ALPHA_SEP;
				end else if (ppmd_pkg::is_ws(b)) begin
					phase_nx = PH_PRE_WS;
				end else begin
					kind = ppmd_pkg::KIND_ERROR;
				end
			end
			PH_ALPHA_SEP: begin
				if (ppmd_pkg::is_ws(b)) phase_nx = PH_PRE_WS;
				else kind = ppmd_pkg::KIND_ERROR;
			end
			PH_PRE_WS, PH_POST_WS, PH_GAP: begin
				if (!ppmd_pkg::is_ws(b)) begin
					// Only the first non-whitespace byte after the magic may open a comment.
					if (phase_q == PH_PRE_WS && b == ppmd_pkg::CH_HASH) begin
						phase_nx = PH_COMMENT;
					end else if (ppmd_pkg::is_digit(b)) begin
						acc_nx   = {{(ppmd_pkg::ACC_W - 4){1'b0}}, digit};
						phase_nx = PH_DIGITS;
					end else begin
						acc_nx   = '0;
						phase_nx = PH_TAIL;
					end
				end
			end
			PH_COMMENT: begin
				if (b == ppmd_pkg::CH_CR || b == ppmd_pkg::CH_LF) phase_nx = PH_POST_WS;
			end
			PH_DIGITS, PH_TAIL: begin
				if (ppmd_pkg::is_ws(b)) begin
					// End of a token: range check and store.
					acc_nx = '0;
					if (chan_idx_q != 2'd2) begin
						if (acc_q == '0 || acc_q > ppmd_pkg::ACC_W'(ppmd_pkg::MAX_DIM)) begin
							kind = ppmd_pkg::KIND_ERROR;
						end else begin
							if (chan_idx_q == 2'd0) width_nx = acc_q[ppmd_pkg::DIM_W-1:0];
							else height_nx = acc_q[ppmd_pkg::DIM_W-1:0];
							chan_idx_nx = chan_idx_q + 2'd1;
							phase_nx    = PH_GAP;
						end
					end else begin
						if (acc_q == '0 ||
							acc_q > ppmd_pkg::ACC_W'(ppmd_pkg::MAXVAL_LIMIT)) begin
							kind = ppmd_pkg::KIND_ERROR;
						end else begin
							maxval_nx     = acc_q[7:0];
							chan_idx_nx   = 2'd0;
							chan_bytes_nx = '0;
							pix_left_nx   = pix_total;
							phase_nx      = PH_PIXELS;
							kind          = ppmd_pkg::KIND_HEADER;
						end
					end
				end else if (phase_q == PH_DIGITS) begin
					if (ppmd_pkg::is_digit(b)) begin
						if (acc_ext > (ppmd_pkg::ACC_W + 3)'(ppmd_pkg::ACC_CAP))
							acc_nx = ppmd_pkg::ACC_W'(ppmd_pkg::ACC_CAP);
						else
							acc_nx = acc_ext[ppmd_pkg::ACC_W-1:0];
					end else begin
						phase_nx = PH_TAIL;
					end
				end
			end
			PH_PIXELS: begin
				if (chan_idx_q < (alpha_q ? 2'd3 : 2'd2)) begin
					chan_bytes_nx = {chan_bytes_q[15:0], b};
					chan_idx_nx   = chan_idx_q + 2'd1;
				end else begin
					kind          = ppmd_pkg::KIND_PIXEL;
					chan_idx_nx   = 2'd0;
					chan_bytes_nx = '0;
					pix_left_nx   = pix_dec;
					if (pix_dec == '0) begin
						last     = 1'b1;
						phase_nx = PH_WAIT;
					end
				end
			end
			default: begin
				phase_nx = PH_WAIT;
			end
		endcase

		if (kind == ppmd_pkg::KIND_ERROR) phase_nx = PH_WAIT;

		// End of file: anything short of the final pixel is an error, and the
		// parser starts over on the next byte.
		if (item_s1.end_of_file) begin
			if (phase_q != PH_WAIT && !(kind == ppmd_pkg::KIND_PIXEL && last))
				kind = ppmd_pkg::KIND_ERROR;
			phase_nx      = PH_MAGIC_P;
			alpha_nx      = 1'b0;
			acc_nx        = '0;
			width_nx      = '0;
			height_nx     = '0;
			maxval_nx     = '0;
			chan_idx_nx   = 2'd0;
			chan_bytes_nx = '0;
			pix_left_nx   = '0;
		end
	end

	always_comb begin
		result_nx             = '0;
		result_nx.result_kind = kind;
		case (kind)
			ppmd_pkg::KIND_HEADER: begin
				result_nx.image_width  = width_q;
				result_nx.image_height = height_q;
				result_nx.has_alpha    = alpha_q;
			end
			ppmd_pkg::KIND_PIXEL: begin
				result_nx.argb       = pix_argb;
				result_nx.last_pixel = last;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_MAGIC_P;
			alpha_q      <= 1'b0;
			acc_q        <= '0;
			width_q      <= '0;
			height_q     <= '0;
			maxval_q     <= '0;
			chan_idx_q   <= 2'd0;
			chan_bytes_q <= '0;
			pix_left_q   <= '0;
		end else if (advance) begin
			phase_q      <= phase_nx;
			alpha_q      <= alpha_nx;
			acc_q        <= acc_nx;
			width_q      <= width_nx;
			height_q     <= height_nx;
			maxval_q     <= maxval_nx;
			chan_idx_q   <= chan_idx_nx;
			chan_bytes_q <= chan_bytes_nx;
			pix_left_q   <= pix_left_nx;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance && kind != ppmd_pkg::KIND_NONE) begin
			result_valid <= 1'b1;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && kind != ppmd_pkg::KIND_NONE) begin
			result_item <= result_nx;
		end
	end

`ifndef ASSERT_OFF
	// A byte in the input register is never lost while the decode stage stalls.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("input register overwritten while stalled");

	// Once the image is finished or failed, no further result appears.
	a_wait_silent: assert property (@(posedge clk) disable iff (!arst_n)
		advance && phase_q == PH_WAIT |-> kind == ppmd_pkg::KIND_NONE)
		else $error("result produced while waiting for end of file");

	// The last-pixel flag only travels with pixel results.
	a_last_is_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_item.last_pixel
		|-> result_item.result_kind == ppmd_pkg::KIND_PIXEL)
		else $error("last_pixel set on a non-pixel result");

	// The result register never presents the internal no-result code.
	a_kind_real: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result_item.result_kind != ppmd_pkg::KIND_NONE)
		else $error("result register holds no-result kind");
`endif

endmodule

// File: verif/ppm_stream_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppm_stream_decoder_tb: self-checking testbench of the PPM stream decoder
// Feeds whole PPM files, well formed and damaged, one byte item at a time,
// predicts every header, pixel and error result with an independent decoder
// model held in a small scoreboard class, and compares each result item field
// by field under random idling on both channels.
// ----------------------------------------------------------------------------
module ppm_stream_decoder_tb;

	// Number of random byte items after the directed files.
	localparam int RANDOM_ITEMS = 650;
	// Our own accumulator ceiling; anything this large fails every range check.
	localparam int unsigned ACC_CEILING = 65536;

	// Where the predicted decoder stands within the file.
	typedef enum logic [3:0] {
		PS_MAGIC_P,
		PS_MAGIC_6,
		PS_MAGIC_SEP,
		PS_ALPHA_SEP,
		PS_PRE_WS,
		PS_COMMENT,
		PS_POST_WS,
		PS_DIGITS,
		PS_TAIL,
		PS_GAP,
		PS_PIXELS,
		PS_WAIT
	} parse_step_t;

	// The scoreboard decodes each accepted byte item itself and keeps the
	// results that the block owes us, oldest first.
	class ppm_frame_tracker;
		parse_step_t            step;
		bit                     alpha_on;
		int unsigned            acc;
		logic [13:0]            width_q;
		logic [13:0]            height_q;
		logic [7:0]             maxval_q;
		// Token number while in the header, byte position within a pixel after.
		logic [1:0]             slot;
		logic [23:0]            held;
		int unsigned            pixels_to_go;
		ppmd_pkg::result_item_t pending_results[$];
		int                     failures;

		function new();
			clear();
			failures = 0;
		endfunction

		function void clear();
			step         = PS_MAGIC_P;
			alpha_on     = 1'b0;
			acc          = 0;
			width_q      = '0;
			height_q     = '0;
			maxval_q     = '0;
			slot         = '0;
			held         = '0;
			pixels_to_go = 0;
		endfunction

		function bit blank(logic [7:0] c);
			return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
		endfunction

		function bit numeral(logic [7:0] c);
			return (c >= 8'h30) && (c <= 8'h39);
		endfunction

		// Exact floor(c * maxval / 255).
		function logic [7:0] scaled(logic [7:0] c);
			logic [15:0] prod;
			prod = {8'd0, c} * {8'd0, maxval_q};
			return 8'(prod / 16'd255);
		endfunction

		function void open_token(logic [7:0] c);
			if (numeral(c)) begin
				acc  = 32'(c) - 32'h30;
				step = PS_DIGITS;
			end else begin
				// A token that starts with anything else counts as zero.
				acc  = 0;
				step = PS_TAIL;
			end
		endfunction

		function ppmd_pkg::kind_t close_token();
			int unsigned v;
			v   = acc;
			acc = 0;
			if (slot != 2'd2) begin
				if (v == 0 || v > ppmd_pkg::MAX_DIM) begin
					step = PS_WAIT;
					return ppmd_pkg::KIND_ERROR;
				end
				if (slot == 2'd0)
					width_q = 14'(v);
				else
					height_q = 14'(v);
				slot++;
				step = PS_GAP;
				return ppmd_pkg::KIND_NONE;
			end
			if (v == 0 || v > ppmd_pkg::MAXVAL_LIMIT) begin
				step = PS_WAIT;
				return ppmd_pkg::KIND_ERROR;
			end
			maxval_q     = 8'(v);
			slot         = '0;
			held         = '0;
			pixels_to_go = 32'(width_q) * 32'(height_q);
			step         = PS_PIXELS;
			return ppmd_pkg::KIND_HEADER;
		endfunction

		function void take_byte(ppmd_pkg::byte_item_t it);
			logic [7:0]             b;
			bit                     was_idle;
			ppmd_pkg::kind_t        kind;
			logic [31:0]            argb;
			bit                     last;
			logic [7:0]             a_ch;
			ppmd_pkg::result_item_t r;
			b        = it.data_byte;
			was_idle = (step == PS_WAIT);
			kind     = ppmd_pkg::KIND_NONE;
			argb     = '0;
			last     = 1'b0;
			case (step)
				PS_MAGIC_P: begin
					if (b == ppmd_pkg::CH_P) step = PS_MAGIC_6;
					else kind = ppmd_pkg::KIND_ERROR;
				end
				PS_MAGIC_6: begin
					if (b == ppmd_pkg::CH_SIX) step = PS_MAGIC_SEP;
					else kind = ppmd_pkg::KIND_ERROR;
				end
				PS_MAGIC_SEP: begin
					if (b == ppmd_pkg::CH_LOW_A) begin
						alpha_on = 1'b1;
						step     = PS_ALPHA_SEP;
					end else if (blank(b)) begin
						step = PS_PRE_WS;
					end else begin
						kind = ppmd_pkg::KIND_ERROR;
					end
				end
				PS_ALPHA_SEP: begin
					if (blank(b)) step = PS_PRE_WS;
					else kind = ppmd_pkg::KIND_ERROR;
				end
				PS_PRE_WS: begin
					// Only here may a comment open.
					if (!blank(b)) begin
						if (b == ppmd_pkg::CH_HASH) step = PS_COMMENT;
						else open_token(b);
					end
				end
				PS_COMMENT: begin
					if (b == ppmd_pkg::CH_CR || b == ppmd_pkg::CH_LF) step = PS_POST_WS;
				end
				PS_POST_WS, PS_GAP: begin
					if (!blank(b)) open_token(b);
				end
				PS_DIGITS: begin
					if (blank(b)) begin
						kind = close_token();
					end else if (numeral(b)) begin
						acc = acc * 10 + (32'(b) - 32'h30);
						if (acc > ACC_CEILING) acc = ACC_CEILING;
					end else begin
						step = PS_TAIL;
					end
				end
				PS_TAIL: begin
					if (blank(b)) kind = close_token();
				end
				PS_PIXELS: begin
					if (slot < (alpha_on ? 2'd3 : 2'd2)) begin
						held = {held[15:0], b};
						slot++;
					end else begin
						a_ch = alpha_on ? held[23:16] : ppmd_pkg::OPAQUE;
						argb = {scaled(a_ch), scaled(held[15:8]), scaled(held[7:0]), scaled(b)};
						kind = ppmd_pkg::KIND_PIXEL;
						slot = '0;
						held = '0;
						if (pixels_to_go > 0) pixels_to_go--;
						if (pixels_to_go == 0) begin
							last = 1'b1;
							step = PS_WAIT;
						end
					end
				end
				default: begin
					step = PS_WAIT;
				end
			endcase
			if (kind == ppmd_pkg::KIND_ERROR) step = PS_WAIT;
			// An end of file before the final pixel is an error in place of
			// whatever the byte would have produced; then the next file begins.
			if (it.end_of_file) begin
				if (!was_idle && !(kind == ppmd_pkg::KIND_PIXEL && last))
					kind = ppmd_pkg::KIND_ERROR;
				clear();
			end
			if (kind == ppmd_pkg::KIND_NONE) return;
			r = '0;
			r.result_kind = kind;
			if (kind == ppmd_pkg::KIND_HEADER) begin
				r.image_width  = width_q;
				r.image_height = height_q;
				r.has_alpha    = alpha_on;
			end else if (kind == ppmd_pkg::KIND_PIXEL) begin
				r.argb       = argb;
				r.last_pixel = last;
			end
			pending_results.push_back(r);
		endfunction

		function void report(string field, logic [31:0] want_v, logic [31:0] got_v);
			if (got_v !== want_v) begin
				$display("%0t: %s expected %0h, got %0h", $time, field, want_v, got_v);
				failures++;
			end
		endfunction

		function void match_result(ppmd_pkg::result_item_t got);
			ppmd_pkg::result_item_t want;
			if (pending_results.size() == 0) begin
				$display("%0t: result item with nothing expected, got %h", $time, got);
				failures++;
				return;
			end
			want = pending_results.pop_front();
			report("result_kind", 32'(want.result_kind), 32'(got.result_kind));
			report("argb", want.argb, got.argb);
			report("image_width", 32'(want.image_width), 32'(got.image_width));
			report("image_height", 32'(want.image_height), 32'(got.image_height));
			report("has_alpha", 32'(want.has_alpha), 32'(got.has_alpha));
			report("last_pixel", 32'(want.last_pixel), 32'(got.last_pixel));
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   byte_valid;
	logic                   byte_ready;
	ppmd_pkg::byte_item_t   byte_item;
	logic                   result_valid;
	logic                   result_ready;
	ppmd_pkg::result_item_t result_item;

	ppm_frame_tracker tracker;
	// Bytes of the file being sent; the last one carries the end-of-file mark.
	logic [7:0]       file_q[$];
	int               send_idle_pct;
	int               recv_idle_pct;
	int               bytes_sent;

	ppm_stream_decoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_ready   (byte_ready),
		.byte_item    (byte_item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_item  (result_item)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// The receiver decides afresh each cycle whether it will take a result.
	always @(negedge clk) begin
		result_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// Results are sampled at the rising edge, before the block updates.
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) tracker.match_result(result_item);
	end

	// Offers one byte item from a falling edge and holds it until it is taken.
	// Returns at the falling edge after acceptance.
	task automatic send_item(ppmd_pkg::byte_item_t it);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			byte_valid <= 1'b0;
			@(negedge clk);
		end
		byte_valid <= 1'b1;
		byte_item  <= it;
		@(posedge clk);
		while (!byte_ready) @(posedge clk);
		tracker.take_byte(it);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_file();
		ppmd_pkg::byte_item_t it;
		for (int i = 0; i < file_q.size(); i++) begin
			it.data_byte   = file_q[i];
			it.end_of_file = (i == file_q.size() - 1);
			send_item(it);
		end
	endtask

	// Holds the sender back until every owed result has come out.
	task automatic drain();
		byte_valid <= 1'b0;
		@(negedge clk);
		while (tracker.pending_results.size() != 0) @(negedge clk);
	endtask

	function automatic void add_text(string s);
		for (int i = 0; i < s.len(); i++) file_q.push_back(s[i]);
	endfunction

	// Decimal number, now and then with a leading zero.
	function automatic void add_number(int unsigned v);
		if ($urandom_range(0, 9) == 0) file_q.push_back(ppmd_pkg::CH_ZERO);
		add_text($sformatf("%0d", v));
	endfunction

	function automatic logic [7:0] pick_blank();
		int k;
		k = $urandom_range(0, 5);
		return (k == 5) ? ppmd_pkg::CH_SPACE : ppmd_pkg::CH_TAB + 8'(k);
	endfunction

	// A byte that is neither whitespace nor a digit.
	function automatic logic [7:0] pick_junk();
		logic [7:0] c;
		do c = 8'($urandom_range(0, 255));
		while (tracker.blank(c) || tracker.numeral(c));
		return c;
	endfunction

	// Builds one file. Some are well formed with random sizes, maxval and
	// pixel data; the rest carry one kind of damage chosen by a single roll:
	// line noise, a bad magic byte, a bad header value, an oddly shaped token,
	// huge sizes cut short, a truncated file or bytes trailing the image.
	function automatic void build_file();
		int          roll;
		int          sub;
		int          odd_tok;
		bit          alpha;
		bit          huge;
		int unsigned dims[3];
		int          pix_bytes;
		logic [7:0]  c;
		file_q.delete();
		roll = $urandom_range(0, 99);
		if (roll < 8) begin
			repeat ($urandom_range(1, 6)) file_q.push_back(8'($urandom_range(0, 255)));
			return;
		end
		alpha = 1'($urandom_range(0, 1));
		file_q.push_back(ppmd_pkg::CH_P);
		file_q.push_back(ppmd_pkg::CH_SIX);
		if (alpha) file_q.push_back(ppmd_pkg::CH_LOW_A);
		file_q.push_back(pick_blank());
		if (roll < 16) file_q[$urandom_range(0, file_q.size() - 1)] = pick_junk();
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 2)) file_q.push_back(pick_blank());
		if ($urandom_range(0, 3) == 0) begin
			file_q.push_back(ppmd_pkg::CH_HASH);
			repeat ($urandom_range(0, 5)) begin
				do c = 8'($urandom_range(0, 255));
				while (c == ppmd_pkg::CH_CR || c == ppmd_pkg::CH_LF);
				file_q.push_back(c);
			end
			file_q.push_back($urandom_range(0, 1) ? ppmd_pkg::CH_CR : ppmd_pkg::CH_LF);
			if ($urandom_range(0, 1)) file_q.push_back(pick_blank());
		end
		dims[0] = $urandom_range(1, 3);
		dims[1] = $urandom_range(1, 2);
		huge = (roll >= 16 && roll < 22);
		if (huge) begin
			sub = $urandom_range(0, 2);
			if (sub != 1) dims[0] = ppmd_pkg::MAX_DIM;
			if (sub != 0) dims[1] = ppmd_pkg::MAX_DIM;
		end
		sub = $urandom_range(0, 9);
		dims[2] = (sub < 2) ? 255 : (sub == 2) ? 1 : $urandom_range(1, 255);
		odd_tok = (roll >= 22 && roll < 42) ? $urandom_range(0, 2) : -1;
		sub = $urandom_range(0, 2);
		for (int i = 0; i < 3; i++) begin
			if (i != odd_tok) begin
				add_number(dims[i]);
			end else if (roll < 32) begin
				// Value out of range: zero, just above the limit, or very long.
				if (sub == 0) begin
					add_number(0);
				end else if (sub == 1) begin
					add_number((i == 2) ? ppmd_pkg::MAXVAL_LIMIT + 1 : ppmd_pkg::MAX_DIM + 1);
				end else begin
					add_number(dims[i]);
					repeat ($urandom_range(6, 9))
						file_q.push_back(ppmd_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
				end
			end else begin
				// Token shapes: junk after the digits, junk first, or a stray hash.
				if (sub == 0) begin
					add_number(dims[i]);
					file_q.push_back(pick_junk());
					if ($urandom_range(0, 1)) add_number($urandom_range(0, 99));
				end else if (sub == 1) begin
					file_q.push_back(pick_junk());
					add_number($urandom_range(1, 99));
				end else begin
					file_q.push_back(ppmd_pkg::CH_HASH);
				end
			end
			if (i < 2)
				repeat ($urandom_range(1, 2)) file_q.push_back(pick_blank());
			else
				file_q.push_back(pick_blank());
		end
		pix_bytes = huge ? $urandom_range(0, 6) : dims[0] * dims[1] * (alpha ? 4 : 3);
		repeat (pix_bytes) file_q.push_back(8'($urandom_range(0, 255)));
		if (roll >= 42 && roll < 54)
			repeat ($urandom_range(1, file_q.size() - 1)) void'(file_q.pop_back());
		else if (roll >= 54 && roll < 66)
			repeat ($urandom_range(1, 4)) file_q.push_back(8'($urandom_range(0, 255)));
	endfunction

	initial begin
		int start_count;
		tracker       = new;
		arst_n        = 1'b0;
		byte_valid    = 1'b0;
		byte_item     = '0;
		result_ready  = 1'b0;
		bytes_sent    = 0;
		send_idle_pct = 36;
		recv_idle_pct = 53;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed files. An alpha image of one pixel at full maxval, with the
		// channel extremes, ending exactly on its final pixel.
		file_q.delete();
		add_text("P6a\n1 1 255\n");
		file_q.push_back(8'h00);
		file_q.push_back(8'hFF);
		file_q.push_back(8'h80);
		file_q.push_back(8'h7F);
		send_file();
		// A wrong first magic byte that is also the end of the file.
		file_q.delete();
		file_q.push_back(8'hFF);
		send_file();
		// A file that ends straight after its magic.
		file_q.delete();
		add_text("P6\n");
		send_file();
		drain();

		// Random files in three idling phases: sender lighter, receiver
		// lighter, then both flat out. Each phase ends with the sender held
		// back until the block has caught up, and now and then mid-phase too.
		start_count = bytes_sent;
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 36 : (ph == 1) ? 53 : 0;
			recv_idle_pct = (ph == 0) ? 53 : (ph == 1) ? 36 : 0;
			while (bytes_sent < start_count + (ph + 1) * RANDOM_ITEMS / 3) begin
				build_file();
				send_file();
				if ($urandom_range(0, 19) == 0) drain();
			end
			drain();
		end

		// Let the pipeline settle so that a stray extra result would show.
		repeat (20) @(posedge clk);
		if (tracker.failures == 0 && tracker.pending_results.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		#400000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

// File: filelist.f
sv/ppmd_pkg.sv
sv/ppmd_pixel_scale.sv
sv/ppm_stream_decoder.sv
verif/ppm_stream_decoder_tb.sv
